FILE: hdl/bhsf_pkg.sv
// ---------------------------------------------------------------------------
// Span fill package
// Shared types and constants for the packed monochrome span fill block.
// ---------------------------------------------------------------------------
package bhsf_pkg;

  localparam int unsigned MEM_BYTES_DEF     = 4096;
  localparam int unsigned MAX_ROW_BYTES_DEF = 128;
  localparam int unsigned SPAN_W            = 21;

  localparam logic [7:0] ROW_BYTES_RST = 8'd4;
  localparam logic [7:0] FULL_MASK     = 8'hFF;

  localparam logic [1:0] CMD_DRAW  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [9:0]  x_start;
    logic [9:0]  x_end;
    logic [11:0] row;
    logic [11:0] byte_index;
    logic [7:0]  write_data;
  } bhsf_cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       status;
  } bhsf_rsp_t;

endpackage

FILE: hdl/bitpacked_horizontal_span_fill.sv
// ---------------------------------------------------------------------------
// Packed monochrome span fill
// Screen byte memory with span draw, byte read and byte write commands.
// ---------------------------------------------------------------------------
// A write or a word rejected at decode ends in the decode state, a span past
// the memory in the check state; a read passes the decode, read and write states,
// a draw decode and check, then a read and a write state for each span byte.
// One word at a time. The result strobe lasts one cycle and the receiver cannot
// stall. After reset the memory is cleared one byte per cycle with busy high;
// the row width register is writable throughout.
module bitpacked_horizontal_span_fill #(
  parameter int unsigned MEM_BYTES     = bhsf_pkg::MEM_BYTES_DEF,
  parameter int unsigned MAX_ROW_BYTES = bhsf_pkg::MAX_ROW_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  bhsf_pkg::bhsf_cmd_t cmd_i,
  output logic                busy,
  output logic                done_o,
  output bhsf_pkg::bhsf_rsp_t rsp_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i
);

  import bhsf_pkg::*;

  localparam int unsigned AW = $clog2(MEM_BYTES);

  localparam logic [SPAN_W-1:0] MEM_LIMIT = SPAN_W'(MEM_BYTES);
  localparam logic [AW-1:0]     CLR_LAST  = AW'(MEM_BYTES - 1);
  localparam logic [10:0]       ROW_LIMIT = 11'(MAX_ROW_BYTES);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_WR    = 3'd5;

  logic [7:0] mem [MEM_BYTES];

  logic [2:0]        state_q, state_d;
  logic [AW-1:0]     clr_q, clr_d;
  logic [7:0]        rb_q;
  bhsf_cmd_t         cmd_q;
  logic [SPAN_W-1:0] base_q, base_d;
  logic [SPAN_W-1:0] cur_q, cur_d;
  logic [SPAN_W-1:0] last_q, last_d;
  logic              first_q, first_d;
  logic              rd_mode_q, rd_mode_d;
  logic [7:0]        rdata_q;
  logic              done_q, done_d;
  bhsf_rsp_t         rsp_q, rsp_d;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;

  logic [SPAN_W-1:0] span_first;
  logic [SPAN_W-1:0] span_last;
  logic [7:0]        byte_mask;
  logic              accept;
  logic              addr_bad;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;

  assign span_first = base_q + SPAN_W'(cmd_q.x_start[9:3]);
  assign span_last  = base_q + SPAN_W'(cmd_q.x_end[9:3]);
  assign addr_bad   = (SPAN_W'(cmd_q.byte_index) >= MEM_LIMIT);

  always_comb begin
    byte_mask = FULL_MASK;
    if (first_q) begin
      byte_mask = byte_mask & (FULL_MASK >> cmd_q.x_start[2:0]);
    end
    if (cur_q == last_q) begin
      byte_mask = byte_mask & (FULL_MASK << (3'd7 - cmd_q.x_end[2:0]));
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    base_d    = base_q;
    cur_d     = cur_q;
    last_d    = last_q;
    first_d   = first_q;
    rd_mode_d = rd_mode_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    mem_we    = 1'b0;
    mem_waddr = cur_q[AW-1:0];
    mem_wdata = 8'd0;
    mem_re    = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        state_d         = S_IDLE;
        rsp_d.read_data = 8'd0;
        rsp_d.status    = 1'b0;
        priority if (cmd_q.command == CMD_DRAW) begin
          if (cmd_q.x_start > cmd_q.x_end) begin
            done_d = 1'b1;
          end else if ((rb_q == 8'd0) || ({3'd0, rb_q} > ROW_LIMIT) ||
                       ({1'b0, cmd_q.x_end} >= {rb_q, 3'd0})) begin
            done_d       = 1'b1;
            rsp_d.status = 1'b1;
          end else begin
            base_d  = SPAN_W'(cmd_q.row) * SPAN_W'(rb_q);
            state_d = S_CHK;
          end
        end else if (cmd_q.command == CMD_READ) begin
          if (addr_bad) begin
            done_d       = 1'b1;
            rsp_d.status = 1'b1;
          end else begin
            cur_d     = SPAN_W'(cmd_q.byte_index);
            rd_mode_d = 1'b1;
            state_d   = S_RD;
          end
        end else if (cmd_q.command == CMD_WRITE) begin
          done_d = 1'b1;
          if (addr_bad) begin
            rsp_d.status = 1'b1;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = AW'(cmd_q.byte_index);
            mem_wdata = cmd_q.write_data;
          end
        end else begin
          done_d       = 1'b1;
          rsp_d.status = 1'b1;
        end
      end
      S_CHK: begin
        if (span_last >= MEM_LIMIT) begin
          done_d          = 1'b1;
          rsp_d.read_data = 8'd0;
          rsp_d.status    = 1'b1;
          state_d         = S_IDLE;
        end else begin
          cur_d     = span_first;
          last_d    = span_last;
          first_d   = 1'b1;
          rd_mode_d = 1'b0;
          state_d   = S_RD;
        end
      end
      S_RD: begin
        mem_re  = 1'b1;
        state_d = S_WR;
      end
      S_WR: begin
        if (rd_mode_q) begin
          done_d          = 1'b1;
          rsp_d.read_data = rdata_q;
          rsp_d.status    = 1'b0;
          state_d         = S_IDLE;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = rdata_q | byte_mask;
          first_d   = 1'b0;
          if (cur_q == last_q) begin
            done_d          = 1'b1;
            rsp_d.read_data = 8'd0;
            rsp_d.status    = 1'b0;
            state_d         = S_IDLE;
          end else begin
            cur_d   = cur_q + SPAN_W'(1);
            state_d = S_RD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      rb_q    <= ROW_BYTES_RST;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        rb_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    base_q    <= base_d;
    cur_q     <= cur_d;
    last_q    <= last_d;
    first_q   <= first_d;
    rd_mode_q <= rd_mode_d;
    rsp_q     <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem[cur_q[AW-1:0]];
    end
  end

  a_err_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.status) |-> (rsp_o.read_data == 8'd0))
    else $error("error result carries nonzero data");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  a_single_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results in consecutive cycles");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (busy && !done_o))
    else $error("activity during the clearing pass");

endmodule
